[design/calendar_date_advance_core_assert.svh]
// ----------------------------------------------------------------------------
// calendar_date_advance_core_assert.svh
// Assertion macros for the calendar date advance core.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is applied.
`define CDA_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CDA_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CDA_ASSERT_RST(label, clk, rst_n, prop, msg)
`define CDA_ASSERT_ANY(label, clk, prop, msg)

`endif

`endif

[design/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants and calendar helpers for the date advance core.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned COUNT_W = 10;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_LONG = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;
  localparam logic [WDAY_W-1:0]  WDAY_SUN = 3'd0;
  localparam logic [WDAY_W-1:0]  WDAY_SAT = 3'd6;

  // Divisibility by 25 through the modular inverse: x * inv(25) mod 2^k
  // lands in [0, (2^k-1)/25] exactly when x is a multiple of 25.
  localparam logic [11:0] INV25_MOD4096 = 12'd3113;
  localparam logic [11:0] LIM25_MOD4096 = 12'd163;
  localparam logic [9:0]  INV25_MOD1024 = 10'd41;
  localparam logic [9:0]  LIM25_MOD1024 = 10'd40;

  // Month lengths, January first; February is the common-year value.
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
  } date_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } state_t;

  function automatic logic leap_year(logic [YEAR_W-1:0] y);
    logic [11:0] p4;
    logic [9:0]  p16;
    logic        div4;
    logic        div100;
    logic        div400;
    p4     = 12'(y[13:2] * INV25_MOD4096);
    p16    = 10'(y[13:4] * INV25_MOD1024);
    div4   = (y[1:0] == 2'b00);
    div100 = div4 && (p4 <= LIM25_MOD4096);
    div400 = (y[3:0] == 4'b0000) && (p16 <= LIM25_MOD1024);
    return div400 || (div4 && !div100);
  endfunction

  // Out-of-range months count as 31 days.
  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == 4'd0 || m > MONTH_DEC) begin
      return DAYS_LONG;
    end else if (m == MONTH_FEB && leap) begin
      return DAYS_FEB_LEAP;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

endpackage

[design/calendar_date_advance_core.sv]
// ----------------------------------------------------------------------------
// calendar_date_advance_core
// Each word passes through load, leap settle, one day per cycle and hand-off;
// a new word is taken only after hand-off, and a result still waiting on
// out_ready stalls the hand-off.
// Reset: synchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
`include "calendar_date_advance_core_assert.svh"

module calendar_date_advance_core import cda_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [YEAR_W-1:0]   in_start_year,
  input  logic [MONTH_W-1:0]  in_start_month,
  input  logic [DAY_W-1:0]    in_start_day,
  input  logic [WDAY_W-1:0]   in_start_weekday,
  input  logic [COUNT_W-1:0]  in_days_to_add,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [YEAR_W-1:0]   out_new_year,
  output logic [MONTH_W-1:0]  out_new_month,
  output logic [DAY_W-1:0]    out_new_day,
  output logic [WDAY_W-1:0]   out_new_weekday
);

  // Sequencer:
  //   IDLE - waits for an input word, loads the working date and count.
  //   PREP - lets the leap flag settle for the loaded year.
  //   RUN  - one day per cycle through the day unit until the count is
  //          spent, then hands the date to the output register.
  // The output register is separate, so a new word can be taken while
  // the previous result still waits for out_ready.

  state_t               state_r, state_nxt;
  date_t                date_r, date_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 leap_r;
  date_t                step_date;

  logic                 out_valid_r, out_valid_nxt;
  date_t                out_date_r, out_date_nxt;

  logic                 in_fire;
  logic                 out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  cda_day_unit u_day_unit (
    .cur_date  (date_r),
    .leap      (leap_r),
    .next_date (step_date)
  );

  // Leap flag is registered from the year and trails it. The year only changes on
  // entering January, and February is at least 31 days away.
  always_ff @(posedge clk) begin
    leap_r <= leap_year(date_r.year);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    date_r     <= date_nxt;
    cnt_r      <= cnt_nxt;
    out_date_r <= out_date_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    date_nxt      = date_r;
    cnt_nxt       = cnt_r;
    out_date_nxt  = out_date_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          date_nxt.year  = in_start_year;
          date_nxt.month = in_start_month;
          date_nxt.day   = in_start_day;
          date_nxt.wday  = in_start_weekday;
          cnt_nxt        = in_days_to_add;
          state_nxt      = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_r != '0) begin
          date_nxt = step_date;
          cnt_nxt  = cnt_r - {{(COUNT_W-1){1'b0}}, 1'b1};
        end else if (out_free) begin
          out_date_nxt  = date_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_new_year    = out_date_r.year;
  assign out_new_month   = out_date_r.month;
  assign out_new_day     = out_date_r.day;
  assign out_new_weekday = out_date_r.wday;

  // Checks

  // One word in flight: after an accept the core must stop taking input.
  `CDA_ASSERT_RST(a_single_item, clk, rst_n, in_fire |=> !in_ready, "input taken while busy")

  // The day counter steps down by exactly one per RUN cycle while it is not zero.
  `CDA_ASSERT_RST(a_count_step, clk, rst_n,
    (state_r == ST_RUN && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1),
    "day counter skipped")

  // A result only appears out of RUN with the count spent.
  `CDA_ASSERT_RST(a_result_source, clk, rst_n,
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN && $past(cnt_r) == '0),
    "result posted early")

  // Output valid is cleared by reset.
  `CDA_ASSERT_ANY(a_reset_clear, clk, !rst_n |=> !out_valid_r, "out_valid survived reset")

endmodule

[design/cda_day_unit.sv]
// ----------------------------------------------------------------------------
// cda_day_unit
// Next-day unit: advances a date by one day, with month, year and
// weekday rollover.
// ----------------------------------------------------------------------------
module cda_day_unit import cda_pkg::*; (
  input  date_t cur_date,
  input  logic  leap,
  output date_t next_date
);

  logic [DAY_W-1:0] dim;
  logic [DAY_W:0]   day_inc;

  always_comb begin
    dim       = month_days(cur_date.month, leap);
    day_inc   = {1'b0, cur_date.day} + {{DAY_W{1'b0}}, 1'b1};
    next_date = cur_date;

    if (day_inc > {1'b0, dim}) begin
      next_date.day = DAY_FIRST;
      if (cur_date.month >= MONTH_DEC) begin
        next_date.month = MONTH_JAN;
        next_date.year  = cur_date.year + {{(YEAR_W-1){1'b0}}, 1'b1};
      end else begin
        next_date.month = cur_date.month + {{(MONTH_W-1){1'b0}}, 1'b1};
      end
    end else begin
      next_date.day = day_inc[DAY_W-1:0];
    end

    // weekday 7 also wraps to Sunday
    if (cur_date.wday >= WDAY_SAT) begin
      next_date.wday = WDAY_SUN;
    end else begin
      next_date.wday = cur_date.wday + {{(WDAY_W-1){1'b0}}, 1'b1};
    end
  end

endmodule
